>>> hdl/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// Used by the level cells, the top level and the port checker; depends on nothing.
package bmhq_pkg;

   localparam int KEY_W = 32;
   // Index width covers every node index and fill count up to 65536 entries.
   localparam int IDX_W = 17;
   localparam int LVL_W = 5;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_FETCH = 2'd2
   } tok_op_type;

   // Token that walks down the chain of level cells. It enters a cell with the
   // position of the parent node on the level above.
   typedef struct packed {
      logic                     valid;
      logic                     live;
      tok_op_type               op;
      logic signed [KEY_W-1:0]  key;
      logic [IDX_W-1:0]         gidx;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         path;
      logic [LVL_W-1:0]         lvl_left;
      logic [IDX_W-1:0]         cnt;
   } tok_type;

   // Write of a parent slot, sent from a cell to the cell above it.
   typedef struct packed {
      logic                     valid;
      logic signed [KEY_W-1:0]  key;
   } wb_type;

   function automatic tok_type tok_advance(tok_type t, logic d);
      tok_type n;
      n          = t;
      n.row      = {t.row[IDX_W-2:0], d};
      n.gidx     = {t.gidx[IDX_W-2:0], 1'b1} + IDX_W'(d);
      n.path     = {t.path[IDX_W-2:0], 1'b0};
      n.lvl_left = t.lvl_left - LVL_W'(1);
      return n;
   endfunction

   function automatic logic [LVL_W-1:0] msb_pos(logic [IDX_W-1:0] v);
      logic [LVL_W-1:0] p;
      p = '0;
      for (int i = 0; i < IDX_W; i++) begin
         if (v[i]) begin
            p = LVL_W'(i);
         end
      end
      return p;
   endfunction

   // Branch bits below the leading one of a 1-based node number, MSB aligned.
   function automatic logic [IDX_W-1:0] path_of(logic [IDX_W-1:0] v);
      logic [LVL_W-1:0] sh;
      sh = LVL_W'(IDX_W) - msb_pos(v);
      return v << sh;
   endfunction

endpackage

>>> hdl/bmhq_cell.sv
// One level of the heap: two banks holding the left and right children of
// every node on the level above. Depends on bmhq_pkg.
module bmhq_cell #(
   parameter int LEVEL = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  bmhq_pkg::tok_type tok_in,
   output bmhq_pkg::tok_type tok_out,
   input  bmhq_pkg::wb_type  wb_dn,
   output bmhq_pkg::wb_type  wb_up
);

   localparam int KW   = bmhq_pkg::KEY_W;
   localparam int IW   = bmhq_pkg::IDX_W;
   localparam int LW   = bmhq_pkg::LVL_W;
   localparam int AW   = (LEVEL > 1) ? LEVEL - 1 : 1;
   localparam int ROWS = 1 << AW;

   logic signed [KW-1:0] mem_l [ROWS];
   logic signed [KW-1:0] mem_r [ROWS];
   logic signed [KW-1:0] rd_l_ff;
   logic signed [KW-1:0] rd_r_ff;

   bmhq_pkg::tok_type a_ff;
   bmhq_pkg::tok_type tok_out_ff;
   bmhq_pkg::tok_type b_tok;
   bmhq_pkg::tok_type tok_out_in;
   logic [AW-1:0]     wr_row_ff;
   logic              wr_d_ff;

   logic              need_work;
   logic              d_path;
   logic              b_d;
   logic signed [KW-1:0] node;
   logic signed [KW-1:0] child;
   logic [IW:0]       cnt_x;
   logic [IW:0]       lc;
   logic [IW:0]       rc;
   logic [IW:0]       ci;
   logic [IW:0]       gc;
   logic              pick_r;
   logic              own_we;
   logic              own_d;
   logic signed [KW-1:0] own_key;
   logic              hold_wr;
   logic              we_l;
   logic              we_r;
   logic [AW-1:0]     wa;
   logic signed [KW-1:0] wd;

   // Fetch tokens only stop at their target level; all others just pass.
   assign need_work = tok_in.valid && tok_in.live &&
                      (tok_in.op != bmhq_pkg::OP_FETCH || tok_in.lvl_left == LW'(1));

   assign d_path = a_ff.path[IW-1];
   assign node   = d_path ? rd_r_ff : rd_l_ff;
   assign cnt_x  = {1'b0, a_ff.cnt};
   assign lc     = {a_ff.gidx, 1'b1};
   assign rc     = lc + (IW+1)'(1);
   assign pick_r = (rc < cnt_x) && ($signed(rd_r_ff) < $signed(rd_l_ff));
   assign child  = pick_r ? rd_r_ff : rd_l_ff;
   assign ci     = lc + (IW+1)'(pick_r);
   assign gc     = {ci[IW-1:0], 1'b1};

   always_comb begin
      b_tok   = a_ff;
      b_d     = d_path;
      own_we  = 1'b0;
      own_d   = d_path;
      own_key = a_ff.key;
      hold_wr = 1'b0;
      wb_up   = '0;
      if (a_ff.valid) begin
         case (a_ff.op)
            bmhq_pkg::OP_PUSH: begin
               if (a_ff.lvl_left == LW'(1)) begin
                  own_we     = 1'b1;
                  b_tok.live = 1'b0;
               end else if ($signed(a_ff.key) < $signed(node)) begin
                  own_we    = 1'b1;
                  b_tok.key = node;
               end
            end
            bmhq_pkg::OP_FETCH: begin
               b_tok.key  = node;
               b_tok.live = 1'b0;
            end
            bmhq_pkg::OP_POP: begin
               b_d = pick_r;
               if (lc >= cnt_x) begin
                  wb_up.valid = 1'b1;
                  wb_up.key   = a_ff.key;
                  b_tok.live  = 1'b0;
               end else if ($signed(child) < $signed(a_ff.key)) begin
                  wb_up.valid = 1'b1;
                  wb_up.key   = child;
                  // When the child has no children of its own the key settles here.
                  if (gc < cnt_x) begin
                     hold_wr = 1'b1;
                  end else begin
                     own_we     = 1'b1;
                     own_d      = pick_r;
                     b_tok.live = 1'b0;
                  end
               end else begin
                  wb_up.valid = 1'b1;
                  wb_up.key   = a_ff.key;
                  b_tok.live  = 1'b0;
               end
            end
            default: begin
               b_tok.live = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      tok_out_in = '0;
      if (a_ff.valid) begin
         tok_out_in = bmhq_pkg::tok_advance(b_tok, b_d);
      end else if (tok_in.valid && !need_work) begin
         tok_out_in = bmhq_pkg::tok_advance(tok_in, tok_in.path[IW-1]);
      end
   end

   assign we_l = (own_we && !own_d) || (!own_we && wb_dn.valid && !wr_d_ff);
   assign we_r = (own_we && own_d) || (!own_we && wb_dn.valid && wr_d_ff);
   assign wa   = own_we ? a_ff.row[AW-1:0] : wr_row_ff;
   assign wd   = own_we ? own_key : wb_dn.key;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid       <= 1'b0;
         tok_out_ff.valid <= 1'b0;
      end else begin
         a_ff       <= tok_in;
         a_ff.valid <= need_work;
         tok_out_ff <= tok_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (need_work) begin
         rd_l_ff <= mem_l[tok_in.row[AW-1:0]];
         rd_r_ff <= mem_r[tok_in.row[AW-1:0]];
      end
      if (we_l) begin
         mem_l[wa] <= wd;
      end
      if (we_r) begin
         mem_r[wa] <= wd;
      end
      if (hold_wr) begin
         wr_row_ff <= a_ff.row[AW-1:0];
         wr_d_ff   <= pick_r;
      end
   end

   assign tok_out = tok_out_ff;

endmodule

>>> hdl/binary_min_heap_queue.sv
// Binary min-heap priority queue: root register plus a chain of level cells.
// Depends on bmhq_pkg and bmhq_cell.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// req_type selects a push of req_key_in or a pop of the smallest key. Every
// request gives exactly one response, shown for one cycle with rsp_strobe
// high: the smallest key held (zero when empty), the empty flag, the fill
// count and a status (ok, push refused when full, pop refused when empty).
// Refused requests leave the heap untouched. The receiver cannot stall; a
// new request may be taken in the cycle that shows the previous response.
// With LEVELS = clog2(CAPACITY+1), each heap level below the root is one
// cell. A token walks down the cells: a cell that works on it holds it in
// the read stage (bank read) and then in the output stage (compare and
// write); a cell it passes only loads it into the output stage. A pop
// first fetches the last entry and then sifts it down from the root.
// Refused requests, a push into an empty heap and a pop of the only entry
// go from idle straight to the done state, with no token sent down.
// Reset empties the heap at once and drops any request in flight.
module binary_min_heap_queue #(
   parameter int  CAPACITY = 1024,
   localparam int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_type,
   input  logic signed [31:0]   req_key_in,
   output logic                 rsp_strobe,
   output logic signed [31:0]   rsp_min_key,
   output logic                 rsp_heap_empty,
   output logic [CW-1:0]        rsp_entries_held,
   output logic [1:0]           rsp_status
);

   localparam int KW    = bmhq_pkg::KEY_W;
   localparam int IW    = bmhq_pkg::IDX_W;
   localparam int NCELL = CW - 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_SIFT  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type            state_ff;
   logic signed [KW-1:0] root_ff;
   logic [CW-1:0]        count_ff;
   logic [1:0]           status_ff;
   bmhq_pkg::tok_type    launch_ff;
   logic                 rsp_strobe_ff;
   logic signed [KW-1:0] rsp_min_key_ff;
   logic                 rsp_empty_ff;
   logic [CW-1:0]        rsp_count_ff;
   logic [1:0]           rsp_status_ff;

   bmhq_pkg::tok_type    chain [NCELL+1];
   bmhq_pkg::wb_type     wb    [NCELL+1];

   logic                 accept;
   logic [IW-1:0]        n_x;
   logic [IW-1:0]        n_p1;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign n_x    = IW'(count_ff);
   assign n_p1   = n_x + IW'(1);

   assign chain[0]  = launch_ff;
   assign wb[NCELL] = '0;

   for (genvar g = 0; g < NCELL; g++) begin : g_level
      bmhq_cell #(
         .LEVEL (g + 1)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[g]),
         .tok_out (chain[g+1]),
         .wb_dn   (wb[g+1]),
         .wb_up   (wb[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         launch_ff.valid <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         launch_ff.valid <= 1'b0;
         rsp_strobe_ff   <= (state_ff == S_DONE);
         if (wb[0].valid) begin
            root_ff <= wb[0].key;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  status_ff <= bmhq_pkg::ST_OK;
                  if (req_type == bmhq_pkg::REQ_PUSH) begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_ff <= bmhq_pkg::ST_FULL;
                        state_ff  <= S_DONE;
                     end else if (count_ff == '0) begin
                        root_ff  <= req_key_in;
                        count_ff <= CW'(1);
                        state_ff <= S_DONE;
                     end else begin
                        // The smaller of key and root stays; the other walks down.
                        count_ff <= count_ff + CW'(1);
                        if (req_key_in < root_ff) begin
                           root_ff       <= req_key_in;
                           launch_ff.key <= root_ff;
                        end else begin
                           launch_ff.key <= req_key_in;
                        end
                        launch_ff.valid    <= 1'b1;
                        launch_ff.live     <= 1'b1;
                        launch_ff.op       <= bmhq_pkg::OP_PUSH;
                        launch_ff.gidx     <= '0;
                        launch_ff.row      <= '0;
                        launch_ff.path     <= bmhq_pkg::path_of(n_p1);
                        launch_ff.lvl_left <= bmhq_pkg::msb_pos(n_p1);
                        launch_ff.cnt      <= n_p1;
                        state_ff           <= S_SIFT;
                     end
                  end else begin
                     if (count_ff == '0) begin
                        status_ff <= bmhq_pkg::ST_EMPTY;
                        state_ff  <= S_DONE;
                     end else if (count_ff == CW'(1)) begin
                        count_ff <= '0;
                        state_ff <= S_DONE;
                     end else begin
                        // Fetch the last entry before anything moves.
                        count_ff           <= count_ff - CW'(1);
                        launch_ff.valid    <= 1'b1;
                        launch_ff.live     <= 1'b1;
                        launch_ff.op       <= bmhq_pkg::OP_FETCH;
                        launch_ff.key      <= root_ff;
                        launch_ff.gidx     <= '0;
                        launch_ff.row      <= '0;
                        launch_ff.path     <= bmhq_pkg::path_of(n_x);
                        launch_ff.lvl_left <= bmhq_pkg::msb_pos(n_x);
                        launch_ff.cnt      <= n_x;
                        state_ff           <= S_FETCH;
                     end
                  end
               end
            end
            S_FETCH: begin
               if (chain[NCELL].valid) begin
                  launch_ff.valid    <= 1'b1;
                  launch_ff.live     <= 1'b1;
                  launch_ff.op       <= bmhq_pkg::OP_POP;
                  launch_ff.key      <= chain[NCELL].key;
                  launch_ff.gidx     <= '0;
                  launch_ff.row      <= '0;
                  launch_ff.path     <= '0;
                  launch_ff.lvl_left <= '0;
                  launch_ff.cnt      <= n_x;
                  state_ff           <= S_SIFT;
               end
            end
            S_SIFT: begin
               if (chain[NCELL].valid) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         rsp_min_key_ff <= (count_ff != '0) ? root_ff : '0;
         rsp_empty_ff   <= (count_ff == '0);
         rsp_count_ff   <= count_ff;
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_min_key      = rsp_min_key_ff;
   assign rsp_heap_empty   = rsp_empty_ff;
   assign rsp_entries_held = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> hdl/bmhq_checker.sv
// Port-level checks for the binary min-heap queue, bound to the top level.
// Depends on bmhq_pkg and binary_min_heap_queue.
module bmhq_checker #(
   parameter int  CAPACITY = 1024,
   localparam int CW       = $clog2(CAPACITY + 1)
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_min_key,
   input logic               rsp_heap_empty,
   input logic [CW-1:0]      rsp_entries_held,
   input logic [1:0]         rsp_status
);

   // An accepted request always leaves the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // The done state always returns to idle, so responses never abut.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held two cycles");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_heap_empty == (rsp_entries_held == '0)))
      else $error("empty flag disagrees with fill count");

   a_empty_min_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_heap_empty) |-> (rsp_min_key == '0))
      else $error("empty heap reports a nonzero minimum");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == bmhq_pkg::ST_OK || rsp_status == bmhq_pkg::ST_FULL ||
                      rsp_status == bmhq_pkg::ST_EMPTY))
      else $error("response status code out of range");

endmodule

bind binary_min_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (.*);

>>> verif/tb_binary_min_heap_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_min_heap_queue: push and pop requests against
// a behavioral min-heap predictor. Depends on bmhq_pkg and the heap RTL only.
module tb_binary_min_heap_queue;

   localparam int HEAP_CAP    = 1024;
   localparam int CNT_W       = $clog2(HEAP_CAP + 1);
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct {
      logic signed [31:0] min_key;
      logic               heap_empty;
      logic [CNT_W-1:0]   entries_held;
      logic [1:0]         status;
   } heap_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                req_type = bmhq_pkg::REQ_PUSH;
   logic signed [31:0]  req_key_in = '0;
   logic                busy;
   logic                rsp_strobe;
   logic signed [31:0]  rsp_min_key;
   logic                rsp_heap_empty;
   logic [CNT_W-1:0]    rsp_entries_held;
   logic [1:0]          rsp_status;

   // Predicted heap contents and fill level.
   logic signed [31:0]  heap_keys [HEAP_CAP];
   int unsigned         heap_fill = 0;
   heap_reply_type      expected_replies [$];
   int                  error_count = 0;
   int                  cycle_count = 0;

   binary_min_heap_queue #(.CAPACITY(HEAP_CAP)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_key_in       (req_key_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_min_key      (rsp_min_key),
      .rsp_heap_empty   (rsp_heap_empty),
      .rsp_entries_held (rsp_entries_held),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void heap_swap(int unsigned a, int unsigned b);
      logic signed [31:0] t;
      t = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = t;
   endfunction

   // Appends the key and moves it up while the parent is not strictly smaller.
   function automatic void heap_insert(logic signed [31:0] k);
      int unsigned pos;
      int unsigned up;
      heap_keys[heap_fill] = k;
      pos = heap_fill;
      heap_fill++;
      while (pos != 0) begin
         up = (pos - 1) / 2;
         if (heap_keys[up] < heap_keys[pos]) break;
         heap_swap(pos, up);
         pos = up;
      end
   endfunction

   // Moves the last entry to the root and sinks it below smaller children.
   function automatic void heap_remove_min();
      int unsigned pos;
      int unsigned lc;
      int unsigned pick;
      heap_fill--;
      heap_keys[0] = heap_keys[heap_fill];
      pos = 0;
      forever begin
         lc = 2 * pos + 1;
         if (lc >= heap_fill) break;
         pick = lc;
         if (lc + 1 < heap_fill && heap_keys[lc + 1] < heap_keys[lc]) pick = lc + 1;
         if (!(heap_keys[pick] < heap_keys[pos])) break;
         heap_swap(pos, pick);
         pos = pick;
      end
   endfunction

   function automatic heap_reply_type predict_reply(logic typ, logic signed [31:0] k);
      heap_reply_type r;
      r.status = bmhq_pkg::ST_OK;
      if (typ == bmhq_pkg::REQ_PUSH) begin
         if (heap_fill >= HEAP_CAP) r.status = bmhq_pkg::ST_FULL;
         else heap_insert(k);
      end else begin
         if (heap_fill == 0) r.status = bmhq_pkg::ST_EMPTY;
         else heap_remove_min();
      end
      r.min_key      = (heap_fill != 0) ? heap_keys[0] : '0;
      r.heap_empty   = (heap_fill == 0);
      r.entries_held = CNT_W'(heap_fill);
      return r;
   endfunction

   // Mostly full-range keys, with clusters of small values for duplicates and
   // the two signed extremes now and then.
   function automatic logic signed [31:0] random_key();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick < 4) return 32'(signed'($urandom_range(0, 16)) - 8);
      if (pick == 4) return 32'sh7FFF_FFFF;
      if (pick == 5) return 32'sh8000_0000;
      return $urandom;
   endfunction

   // Holds the request on the ports until the block takes it, then records
   // the response it must produce. Start stays high on return.
   task automatic send_request(input logic typ, input logic signed [31:0] k);
      req_type   <= typ;
      req_key_in <= k;
      start      <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      expected_replies.push_back(predict_reply(typ, k));
   endtask

   task automatic idle_burst(input bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic test_directed();
      send_request(bmhq_pkg::REQ_POP, 32'sh1234_5678);
      send_request(bmhq_pkg::REQ_PUSH, 32'sd0);
      send_request(bmhq_pkg::REQ_POP, '0);
      send_request(bmhq_pkg::REQ_PUSH, 32'sh7FFF_FFFF);
      idle_burst(1'b1);
      send_request(bmhq_pkg::REQ_PUSH, 32'sh8000_0000);
      send_request(bmhq_pkg::REQ_PUSH, -32'sd1);
      send_request(bmhq_pkg::REQ_PUSH, 32'sd1);
      send_request(bmhq_pkg::REQ_PUSH, 32'sd5);
      idle_burst(1'b1);
      send_request(bmhq_pkg::REQ_PUSH, 32'sd5);
      send_request(bmhq_pkg::REQ_PUSH, 32'sd5);
      send_request(bmhq_pkg::REQ_PUSH, -32'sd5);
      repeat (9) begin
         send_request(bmhq_pkg::REQ_POP, $urandom);
         idle_burst(1'b1);
      end
      send_request(bmhq_pkg::REQ_POP, 32'shFFFF_FFFF);
   endtask

   // Fills the heap to capacity, checks refused pushes, and refills after a
   // few pops so the deepest level is written more than once.
   task automatic test_full_heap();
      while (heap_fill < HEAP_CAP) begin
         send_request(bmhq_pkg::REQ_PUSH, random_key());
         idle_burst($urandom_range(0, 7) == 0);
      end
      send_request(bmhq_pkg::REQ_PUSH, 32'sh8000_0000);
      send_request(bmhq_pkg::REQ_PUSH, random_key());
      repeat (5) send_request(bmhq_pkg::REQ_POP, random_key());
      while (heap_fill < HEAP_CAP) send_request(bmhq_pkg::REQ_PUSH, random_key());
      send_request(bmhq_pkg::REQ_PUSH, random_key());
   endtask

   // Phases with different push weights let the fill level climb and fall.
   task automatic test_random_mix(input int phases, input int per_phase, input bit gaps);
      int unsigned push_weight;
      repeat (phases) begin
         push_weight = $urandom_range(20, 85);
         repeat (per_phase) begin
            if ($urandom_range(1, 100) <= push_weight) begin
               send_request(bmhq_pkg::REQ_PUSH, random_key());
            end else begin
               send_request(bmhq_pkg::REQ_POP, random_key());
            end
            idle_burst(gaps);
         end
      end
   endtask

   always @(posedge clock) begin : reply_check
      heap_reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_replies.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_min_key !== want.min_key) begin
               $error("min_key: expected %0d, got %0d", want.min_key, rsp_min_key);
               error_count++;
            end
            if (rsp_heap_empty !== want.heap_empty) begin
               $error("heap_empty: expected %0b, got %0b", want.heap_empty, rsp_heap_empty);
               error_count++;
            end
            if (rsp_entries_held !== want.entries_held) begin
               $error("entries_held: expected %0d, got %0d",
                      want.entries_held, rsp_entries_held);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_heap();
      test_random_mix(2, 25, 1'b1);
      // Closing stretch: requests back to back with no gaps.
      test_random_mix(1, 25, 1'b0);
      start <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/bmhq_pkg.sv
hdl/bmhq_cell.sv
hdl/binary_min_heap_queue.sv
hdl/bmhq_checker.sv
verif/tb_binary_min_heap_queue.sv
